// File: design/swd_pkg.sv
// Package with widths, codes and types shared by the stack unit, its interfaces and its checker.
`timescale 1ns / 1ps
package swd_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [KIND_W-1:0]        t_kind;
    typedef logic [STATUS_W-1:0]      t_status;
    typedef logic [COUNT_W-1:0]       t_count;

    localparam t_kind KIND_PUSH   = 2'd0;
    localparam t_kind KIND_POP    = 2'd1;
    localparam t_kind KIND_DELETE = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    localparam t_data DATA_NEG_ONE = '1;

    typedef struct packed {
        t_data   removed_value;
        t_status status;
        t_data   top_value;
        t_count  count;
        logic    is_empty;
    } t_result;

endpackage

// File: design/swd_if.sv
// Valid/ready channel interfaces for the operation beats and the result beats.
`timescale 1ns / 1ps
interface swd_in_if import swd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_data value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

interface swd_out_if import swd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_data   removed_value;
    t_status status;
    t_data   top_value;
    t_count  count;
    logic    is_empty;

    modport source (output valid, output removed_value, output status, output top_value,
                    output count, output is_empty, input ready);
    modport sink (input valid, input removed_value, input status, input top_value,
                  input count, input is_empty, output ready);
endinterface

// File: design/stack_with_delete_by_value_unit.sv
// LIFO stack with delete by value, held in one synchronous memory.
// Push, an unused kind, a push to a full stack and a pop or delete on an empty stack go straight to
// the result state. Pop first reads the new top back from the memory, unless it empties the stack.
// Delete scans down one entry per cycle, then moves each entry above the match down one per
// cycle; a top match with entries left reads the new top back from the memory instead.
// One operation is in work at a time. Reset clears the count and the control; no memory sweep.
`timescale 1ns / 1ps
module stack_with_delete_by_value_unit import swd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swd_in_if.sink     i_in,
    swd_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_TOP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_addr, n_addr;
    t_data            r_top, n_top;
    t_data            r_value, n_value;
    t_data            r_removed, n_removed;
    t_status          r_status, n_status;
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_out;
    logic             out_load;
    logic             in_fire;

    t_data            r_mem [DEPTH];
    t_data            r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    t_data            mem_wdata;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_top     = r_top;
        n_value   = r_value;
        n_removed = r_removed;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata;
        mem_raddr = r_addr;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_value   = i_in.value;
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_state   = S_DONE;
                    case (i_in.kind)
                        KIND_PUSH: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = IDX_W'(r_count);
                                mem_wdata = i_in.value;
                                n_count   = r_count + 1'b1;
                                n_top     = i_in.value;
                            end
                        end
                        KIND_POP: begin
                            if (r_count == '0) begin
                                n_removed = DATA_NEG_ONE;
                                n_status  = ST_EMPTY;
                            end else begin
                                n_removed = r_top;
                                n_count   = r_count - 1'b1;
                                if (r_count != CNT_W'(1)) begin
                                    mem_raddr = IDX_W'(r_count - CNT_W'(2));
                                    n_state   = S_TOP;
                                end
                            end
                        end
                        KIND_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                mem_raddr = IDX_W'(r_count - 1'b1);
                                n_addr    = IDX_W'(r_count - 1'b1);
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rdata == r_value) begin
                    if (CNT_W'(r_addr) == r_count - 1'b1) begin
                        n_count = r_count - 1'b1;
                        if (r_count != CNT_W'(1)) begin
                            mem_raddr = IDX_W'(r_count - CNT_W'(2));
                            n_state   = S_TOP;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        mem_raddr = r_addr + 1'b1;
                        n_state   = S_SHIFT;
                    end
                end else if (r_addr == '0) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    mem_raddr = r_addr - 1'b1;
                    n_addr    = r_addr - 1'b1;
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = r_rdata;
                if (CNT_W'(r_addr) + CNT_W'(2) == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = IDX_W'(CNT_W'(r_addr) + CNT_W'(2));
                    n_addr    = r_addr + 1'b1;
                end
            end
            S_TOP: begin
                n_top   = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out.removed_value = r_removed;
        n_out.status        = r_status;
        n_out.top_value     = (r_count == '0) ? DATA_NEG_ONE : r_top;
        n_out.count         = COUNT_W'(r_count);
        n_out.is_empty      = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= out_load || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_top     <= n_top;
        r_value   <= n_value;
        r_removed <= n_removed;
        r_status  <= n_status;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_out.removed_value;
    assign o_out.status        = r_out.status;
    assign o_out.top_value     = r_out.top_value;
    assign o_out.count         = r_out.count;
    assign o_out.is_empty      = r_out.is_empty;

endmodule

// File: design/swd_checker.sv
// Port-level checker for the stack unit and the bind that attaches it.
`timescale 1ns / 1ps
module swd_checker import swd_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_data   i_removed_value,
    input t_status i_status,
    input t_data   i_top_value,
    input t_count  i_count,
    input logic    i_is_empty
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("A stalled result beat was dropped.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_count) <= DEPTH))
        else $error("Result count exceeds the stack depth.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_empty == (i_count == '0)))
        else $error("Empty flag disagrees with the count.");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_empty |-> (i_top_value == DATA_NEG_ONE))
        else $error("Top value of an empty stack is not minus one.");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY) |->
            (i_removed_value == DATA_NEG_ONE) && i_is_empty)
        else $error("Pop of an empty stack reported wrongly.");

endmodule

bind stack_with_delete_by_value_unit swd_checker u_swd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_removed_value (o_out.removed_value),
    .i_status        (o_out.status),
    .i_top_value     (o_out.top_value),
    .i_count         (o_out.count),
    .i_is_empty      (o_out.is_empty)
);
